// ----- sv/ring_deque_index_access_macros.svh -----
// Assertion macros shared by the ring deque block.
`ifndef RING_DEQUE_INDEX_ACCESS_MACROS_SVH
`define RING_DEQUE_INDEX_ACCESS_MACROS_SVH
`ifndef SYNTHESIS
`define RDAI_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rdai: same-cycle check failed");
`define RDAI_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rdai: next-cycle check failed");
`else
`define RDAI_ASSERT_SAME(lbl, ante, cons)
`define RDAI_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ----- sv/rdai_pkg.sv -----
// Package with constants, types and helpers of the ring deque block.
`timescale 1ns / 1ps
package rdai_pkg;

  localparam int DEPTH      = 1024;
  localparam int ADDR_W     = $clog2(DEPTH);
  localparam int CNT_W      = ADDR_W + 1;
  localparam int DATA_W     = 32;
  localparam int IDX_W      = 10;
  localparam int HEAD_W     = 10;
  localparam int LEN_W      = 11;
  localparam int CMD_W      = 3;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 11;
  localparam int SUM_W      = (ADDR_W > IDX_W) ? ADDR_W : IDX_W;

  typedef enum logic [CMD_W-1:0] {
    CMD_GET    = 3'd0,
    CMD_SET    = 3'd1,
    CMD_SWAP   = 3'd2,
    CMD_SORTED = 3'd3,
    CMD_MAX    = 3'd4
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HEAD_OFFSET = 1'b0,
    REG_USED_LENGTH = 1'b1
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECODE,
    ST_READ_A,
    ST_READ_B,
    ST_WRITE_A,
    ST_WRITE_B,
    ST_WRITE_SET,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic in_ready;
    logic clearing;
    logic load_item;
    logic clr_wr;
    logic rd_a;
    logic rd_b;
    logic hold_a;
    logic wr_a;
    logic wr_b;
    logic wr_set;
    logic scan_rd;
    logic res_load;
  } ctl_t;

  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic             err_a;
    logic             err_swap;
    logic             scan_empty;
    logic             scan_last;
    logic             clear_last;
    logic             out_free;
  } sts_t;

  function automatic logic [ADDR_W-1:0] slot_of(input logic [HEAD_W-1:0] head,
                                                 input logic [SUM_W-1:0] logical);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(head) + logical;
    return sum[ADDR_W-1:0];
  endfunction

endpackage

// ----- sv/rdai_if.sv -----
// Handshake interfaces for the command and result channels.
`timescale 1ns / 1ps
interface rdai_cmd_if;
  logic                                valid;
  logic                                ready;
  logic        [rdai_pkg::CMD_W-1:0]   command;
  logic        [rdai_pkg::IDX_W-1:0]   index_a;
  logic        [rdai_pkg::IDX_W-1:0]   index_b;
  logic signed [rdai_pkg::DATA_W-1:0]  write_value;

  modport source (output valid, command, index_a, index_b, write_value, input ready);
  modport sink (input valid, command, index_a, index_b, write_value, output ready);
endinterface

interface rdai_res_if;
  logic                               valid;
  logic                               ready;
  logic signed [rdai_pkg::DATA_W-1:0] read_value;
  logic                               error;
  logic                               is_sorted;

  modport source (output valid, read_value, error, is_sorted, input ready);
  modport sink (input valid, read_value, error, is_sorted, output ready);
endinterface

// ----- sv/ring_deque_index_access.sv -----
// Top level of the ring deque with access by logical index.
//
//   channel  direction  contents
//   cmd      in         command, index_a, index_b, write_value
//   res      out        read_value, error, is_sorted
//   cfg      in         cfg_we, cfg_index, cfg_data (head_offset, used_length)
//
// After reset the entry memory is cleared one entry a cycle, with cmd.ready low.
// Get, set and swap all go through one memory read port and one write port. Sorted check
// and maximum scan make one memory read per used entry. One command is in flight at a
// time; a finished result waits in the output register while the next command is taken.
`timescale 1ns / 1ps
`include "ring_deque_index_access_macros.svh"
module ring_deque_index_access (
  input  logic                                  clk,
  input  logic                                  rst,
  rdai_cmd_if.sink                              cmd,
  rdai_res_if.source                            res,
  input  logic                                  cfg_we,
  input  logic [rdai_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [rdai_pkg::CFG_DATA_W-1:0]       cfg_data
);

  rdai_pkg::ctl_t ctl;
  rdai_pkg::sts_t sts;

  rdai_controller u_controller (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd.valid),
    .sts       (sts),
    .ctl       (ctl)
  );

  rdai_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .ctl         (ctl),
    .sts         (sts),
    .command     (cmd.command),
    .index_a     (cmd.index_a),
    .index_b     (cmd.index_b),
    .write_value (cmd.write_value),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .out_ready   (res.ready),
    .out_valid   (res.valid),
    .read_value  (res.read_value),
    .error       (res.error),
    .is_sorted   (res.is_sorted)
  );

  assign cmd.ready = ctl.in_ready;

  `RDAI_ASSERT_NEXT(a_one_item, cmd.valid && cmd.ready, !cmd.ready)
  `RDAI_ASSERT_NEXT(a_clear_done, ctl.clearing && sts.clear_last, cmd.ready)
  `RDAI_ASSERT_SAME(a_res_from_load, $rose(res.valid), $past(ctl.res_load))

endmodule

// ----- sv/rdai_datapath.sv -----
// Datapath of the ring deque: entry memory, registers, scan unit and result register.
`timescale 1ns / 1ps
module rdai_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  rdai_pkg::ctl_t                      ctl,
  output rdai_pkg::sts_t                      sts,
  input  logic        [rdai_pkg::CMD_W-1:0]   command,
  input  logic        [rdai_pkg::IDX_W-1:0]   index_a,
  input  logic        [rdai_pkg::IDX_W-1:0]   index_b,
  input  logic signed [rdai_pkg::DATA_W-1:0]  write_value,
  input  logic                                cfg_we,
  input  logic        [rdai_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic        [rdai_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                                out_ready,
  output logic                                out_valid,
  output logic signed [rdai_pkg::DATA_W-1:0]  read_value,
  output logic                                error,
  output logic                                is_sorted
);

  logic [rdai_pkg::DATA_W-1:0]   mem [rdai_pkg::DEPTH];
  logic [rdai_pkg::DATA_W-1:0]   rdata;
  logic [rdai_pkg::DATA_W-1:0]   held_a;
  logic [rdai_pkg::DATA_W-1:0]   acc;
  logic [rdai_pkg::HEAD_W-1:0]   head_offset;
  logic [rdai_pkg::LEN_W-1:0]    used_length;
  logic [rdai_pkg::CMD_W-1:0]    item_cmd;
  logic [rdai_pkg::IDX_W-1:0]    item_ia;
  logic [rdai_pkg::IDX_W-1:0]    item_ib;
  logic [rdai_pkg::DATA_W-1:0]   item_wv;
  logic [rdai_pkg::CNT_W-1:0]    cnt;
  logic [rdai_pkg::CNT_W-1:0]    scan_n;
  logic                          rv;
  logic                          first;
  logic                          srt;
  logic [rdai_pkg::ADDR_W-1:0]   pa;
  logic [rdai_pkg::ADDR_W-1:0]   pb;
  logic [rdai_pkg::ADDR_W-1:0]   ps;
  logic                          mem_we;
  logic                          mem_re;
  logic [rdai_pkg::ADDR_W-1:0]   wr_addr;
  logic [rdai_pkg::ADDR_W-1:0]   rd_addr;
  logic [rdai_pkg::DATA_W-1:0]   wr_data;
  logic                          err_a;
  logic                          err_b;
  logic [rdai_pkg::DATA_W-1:0]   res_value;
  logic                          res_error;
  logic                          res_sorted;

  assign pa = rdai_pkg::slot_of(head_offset, rdai_pkg::SUM_W'(item_ia));
  assign pb = rdai_pkg::slot_of(head_offset, rdai_pkg::SUM_W'(item_ib));
  assign ps = rdai_pkg::slot_of(head_offset, rdai_pkg::SUM_W'(cnt));

  assign err_a = {1'b0, item_ia} >= used_length;
  assign err_b = {1'b0, item_ib} >= used_length;

  always_comb begin
    if (32'(used_length) > 32'(rdai_pkg::DEPTH)) begin
      scan_n = rdai_pkg::CNT_W'(rdai_pkg::DEPTH);
    end else begin
      scan_n = rdai_pkg::CNT_W'(used_length);
    end
  end

  assign mem_we  = ctl.clr_wr | ctl.wr_a | ctl.wr_b | ctl.wr_set;
  assign mem_re  = ctl.rd_a | ctl.rd_b | ctl.scan_rd;
  assign wr_addr = ctl.clr_wr ? cnt[rdai_pkg::ADDR_W-1:0] : (ctl.wr_b ? pb : pa);
  assign rd_addr = ctl.rd_b ? pb : (ctl.scan_rd ? ps : pa);

  always_comb begin
    if (ctl.clr_wr) begin
      wr_data = '0;
    end else if (ctl.wr_a) begin
      wr_data = rdata;
    end else if (ctl.wr_b) begin
      wr_data = held_a;
    end else begin
      wr_data = item_wv;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    if (mem_re) begin
      rdata <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head_offset <= '0;
      used_length <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        rdai_pkg::REG_HEAD_OFFSET: head_offset <= cfg_data[rdai_pkg::HEAD_W-1:0];
        rdai_pkg::REG_USED_LENGTH: used_length <= cfg_data[rdai_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      rv        <= 1'b0;
      first     <= 1'b1;
      srt       <= 1'b1;
      out_valid <= 1'b0;
    end else begin
      rv <= ctl.scan_rd;
      if (ctl.load_item) begin
        cnt   <= '0;
        first <= 1'b1;
        srt   <= 1'b1;
      end else begin
        if (ctl.clr_wr || ctl.scan_rd) begin
          cnt <= cnt + rdai_pkg::CNT_W'(1);
        end
        if (rv) begin
          first <= 1'b0;
          if (!first && ($signed(acc) > $signed(rdata))) begin
            srt <= 1'b0;
          end
        end
      end
      if (ctl.res_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_item) begin
      item_cmd <= command;
      item_ia  <= index_a;
      item_ib  <= index_b;
      item_wv  <= write_value;
    end
    if (ctl.hold_a) begin
      held_a <= rdata;
    end
    if (rv) begin
      if (first || (item_cmd != rdai_pkg::CMD_MAX) || ($signed(rdata) > $signed(acc))) begin
        acc <= rdata;
      end
    end
    if (ctl.res_load) begin
      read_value <= res_value;
      error      <= res_error;
      is_sorted  <= res_sorted;
    end
  end

  always_comb begin
    res_value  = '0;
    res_error  = 1'b0;
    res_sorted = 1'b0;
    case (item_cmd)
      rdai_pkg::CMD_GET: begin
        res_error = err_a;
        res_value = err_a ? '0 : rdata;
      end
      rdai_pkg::CMD_SET: res_error = err_a;
      rdai_pkg::CMD_SWAP: res_error = err_a | err_b;
      rdai_pkg::CMD_SORTED: res_sorted = srt;
      rdai_pkg::CMD_MAX: begin
        res_error = (scan_n == '0);
        res_value = (scan_n == '0) ? '0 : acc;
      end
      default: ;
    endcase
  end

  assign sts.command    = item_cmd;
  assign sts.err_a      = err_a;
  assign sts.err_swap   = err_a | err_b;
  assign sts.scan_empty = (scan_n == '0);
  assign sts.scan_last  = (cnt == scan_n - rdai_pkg::CNT_W'(1));
  assign sts.clear_last = (cnt[rdai_pkg::ADDR_W-1:0] == rdai_pkg::ADDR_W'(rdai_pkg::DEPTH - 1));
  assign sts.out_free   = !out_valid || out_ready;

endmodule

// ----- sv/rdai_controller.sv -----
// Controller state machine of the ring deque block.
`timescale 1ns / 1ps
module rdai_controller (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  input  rdai_pkg::sts_t sts,
  output rdai_pkg::ctl_t ctl
);

  rdai_pkg::state_t state;
  rdai_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rdai_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctl        = '0;
    case (state)
      rdai_pkg::ST_CLEAR: begin
        ctl.clearing = 1'b1;
        ctl.clr_wr   = 1'b1;
        if (sts.clear_last) begin
          state_next = rdai_pkg::ST_IDLE;
        end
      end
      rdai_pkg::ST_IDLE: begin
        ctl.in_ready = 1'b1;
        if (cmd_valid) begin
          ctl.load_item = 1'b1;
          state_next    = rdai_pkg::ST_DECODE;
        end
      end
      rdai_pkg::ST_DECODE: begin
        case (sts.command)
          rdai_pkg::CMD_GET:
            state_next = sts.err_a ? rdai_pkg::ST_FINISH : rdai_pkg::ST_READ_A;
          rdai_pkg::CMD_SET:
            state_next = sts.err_a ? rdai_pkg::ST_FINISH : rdai_pkg::ST_WRITE_SET;
          rdai_pkg::CMD_SWAP:
            state_next = sts.err_swap ? rdai_pkg::ST_FINISH : rdai_pkg::ST_READ_A;
          rdai_pkg::CMD_SORTED, rdai_pkg::CMD_MAX:
            state_next = sts.scan_empty ? rdai_pkg::ST_FINISH : rdai_pkg::ST_SCAN;
          default:
            state_next = rdai_pkg::ST_FINISH;
        endcase
      end
      rdai_pkg::ST_READ_A: begin
        ctl.rd_a   = 1'b1;
        state_next = (sts.command == rdai_pkg::CMD_SWAP) ? rdai_pkg::ST_READ_B
                                                         : rdai_pkg::ST_FINISH;
      end
      rdai_pkg::ST_READ_B: begin
        ctl.rd_b   = 1'b1;
        ctl.hold_a = 1'b1;
        state_next = rdai_pkg::ST_WRITE_A;
      end
      rdai_pkg::ST_WRITE_A: begin
        ctl.wr_a   = 1'b1;
        state_next = rdai_pkg::ST_WRITE_B;
      end
      rdai_pkg::ST_WRITE_B: begin
        ctl.wr_b   = 1'b1;
        state_next = rdai_pkg::ST_FINISH;
      end
      rdai_pkg::ST_WRITE_SET: begin
        ctl.wr_set = 1'b1;
        state_next = rdai_pkg::ST_FINISH;
      end
      rdai_pkg::ST_SCAN: begin
        ctl.scan_rd = 1'b1;
        if (sts.scan_last) begin
          state_next = rdai_pkg::ST_DRAIN;
        end
      end
      rdai_pkg::ST_DRAIN: begin
        state_next = rdai_pkg::ST_FINISH;
      end
      rdai_pkg::ST_FINISH: begin
        if (sts.out_free) begin
          ctl.res_load = 1'b1;
          state_next   = rdai_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = rdai_pkg::ST_IDLE;
      end
    endcase
  end

endmodule
